### src/brf_pkg.sv
`default_nettype none

package brf_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BYTES_DEF = 8;

  localparam int CMD_W  = 2;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int CFG_W  = 11;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_TAKE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic wr_byte;
    logic rd_issue;
    logic rd_take;
    logic commit_wr;
    logic commit_rd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_read;
    logic is_clear;
    logic wr_ok;
    logic rd_ok;
    logic bytes_done;
  } dp_status_t;

endpackage

`default_nettype wire

### src/brf_ctrl.sv
`default_nettype none

module brf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire brf_pkg::dp_status_t status,
  output brf_pkg::ctrl_cmd_t      cmd,
  output logic                    busy,
  output logic                    out_valid,
  output logic                    cfg_ready
);

  brf_pkg::state_t state_r;
  brf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brf_pkg::ST_IDLE: begin
        if (start) state_nxt = brf_pkg::ST_DECIDE;
      end
      brf_pkg::ST_DECIDE: begin
        if (status.is_write && status.wr_ok) begin
          state_nxt = brf_pkg::ST_WRITE;
        end else if (status.is_read && status.rd_ok) begin
          state_nxt = brf_pkg::ST_RD_ISSUE;
        end else begin
          state_nxt = brf_pkg::ST_RESULT;
        end
      end
      brf_pkg::ST_WRITE: begin
        if (status.bytes_done) state_nxt = brf_pkg::ST_RESULT;
      end
      brf_pkg::ST_RD_ISSUE: begin
        if (status.bytes_done) begin
          state_nxt = brf_pkg::ST_RESULT;
        end else begin
          state_nxt = brf_pkg::ST_RD_TAKE;
        end
      end
      brf_pkg::ST_RD_TAKE: state_nxt = brf_pkg::ST_RD_ISSUE;
      brf_pkg::ST_RESULT:  state_nxt = brf_pkg::ST_IDLE;
      default:             state_nxt = brf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      brf_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = !start;
        cmd.load  = start;
      end
      brf_pkg::ST_DECIDE: begin
        cmd.clear = status.is_clear;
      end
      brf_pkg::ST_WRITE: begin
        cmd.wr_byte   = !status.bytes_done;
        cmd.commit_wr = status.bytes_done;
      end
      brf_pkg::ST_RD_ISSUE: begin
        cmd.rd_issue  = !status.bytes_done;
        cmd.commit_rd = status.bytes_done;
      end
      brf_pkg::ST_RD_TAKE: begin
        cmd.rd_take = 1'b1;
      end
      brf_pkg::ST_RESULT: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe held beyond one cycle");

  a_take_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_take |-> $past(cmd.rd_issue))
    else $error("byte taken without a preceding read");

  a_load_no_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cfg_ready)
    else $error("capacity write open while a command loads");
`endif

endmodule

`default_nettype wire

### src/brf_datapath.sv
`default_nettype none

module brf_datapath #(
  parameter int DEPTH     = brf_pkg::DEPTH_DEF,
  parameter int MAX_BYTES = brf_pkg::MAX_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire brf_pkg::ctrl_cmd_t           cmd,
  output brf_pkg::dp_status_t               status,
  input  wire logic [brf_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [brf_pkg::LEN_W-1:0]    in_length,
  input  wire logic                         in_remove_after_read,
  input  wire logic [brf_pkg::DATA_W-1:0]   in_write_bytes,
  input  wire logic                         cfg_we,
  input  wire logic [brf_pkg::CFG_W-1:0]    cfg_data,
  output logic [brf_pkg::LEN_W-1:0]         out_transferred,
  output logic [brf_pkg::DATA_W-1:0]        out_read_bytes,
  output logic [brf_pkg::CFG_W-1:0]         out_occupancy,
  output logic                              out_full_res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CAPW  = ($clog2(DEPTH + 1) > brf_pkg::CFG_W) ?
                         $clog2(DEPTH + 1) : brf_pkg::CFG_W;
  localparam int AW    = ((PTR_W > CAPW) ? PTR_W : CAPW) + 1;
  localparam logic [CAPW-1:0] DEPTH_C = CAPW'(DEPTH);
  localparam logic [CAPW-1:0] MAXB_C  = CAPW'(MAX_BYTES);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  logic [brf_pkg::CMD_W-1:0]  cmd_r;
  logic [brf_pkg::LEN_W-1:0]  len_r;
  logic                       rem_r;
  logic [brf_pkg::DATA_W-1:0] wdata_r;
  logic [brf_pkg::LEN_W-1:0]  idx_r;
  logic [PTR_W-1:0]           walk_r;
  logic [PTR_W-1:0]           wp_r;
  logic [PTR_W-1:0]           rp_r;
  logic [CAPW-1:0]            count_r;
  logic [CAPW-1:0]            cap_r;
  logic [brf_pkg::LEN_W-1:0]  moved_r;
  logic [brf_pkg::DATA_W-1:0] rdata_r;

  logic [CAPW-1:0] cfg_ext;
  logic [CAPW-1:0] cap_nxt;
  logic [CAPW-1:0] len_ext;
  logic [CAPW-1:0] space;
  logic            len_legal;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CAPW-1:0]  cap);
    logic [AW-1:0] n;
    n = AW'(p) + AW'(1);
    return (n >= AW'(cap)) ? '0 : n[PTR_W-1:0];
  endfunction

  always_comb begin
    cfg_ext = CAPW'(cfg_data);
    if (cfg_ext == '0) begin
      cap_nxt = CAPW'(1);
    end else if (cfg_ext > DEPTH_C) begin
      cap_nxt = DEPTH_C;
    end else begin
      cap_nxt = cfg_ext;
    end
  end

  assign len_ext   = CAPW'(len_r);
  assign space     = cap_r - count_r;
  assign len_legal = (len_ext <= MAXB_C);

  always_comb begin
    status.is_write   = (cmd_r == brf_pkg::CMD_WRITE);
    status.is_read    = (cmd_r == brf_pkg::CMD_READ);
    status.is_clear   = (cmd_r == brf_pkg::CMD_CLEAR);
    status.wr_ok      = len_legal && (len_ext <= space);
    status.rd_ok      = len_legal && (len_ext <= count_r);
    status.bytes_done = (idx_r == len_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      len_r   <= in_length;
      rem_r   <= in_remove_after_read;
      wdata_r <= in_write_bytes;
      walk_r  <= rp_r;
      moved_r <= '0;
      rdata_r <= '0;
    end
    if (cmd.rd_take) begin
      rdata_r[{idx_r[2:0], 3'b000} +: 8] <= mem_q;
      walk_r <= advance(walk_r, cap_r);
    end
    if (cmd.commit_wr || cmd.commit_rd) begin
      moved_r <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.wr_byte || cmd.rd_take) begin
      idx_r <= idx_r + brf_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= DEPTH_C;
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      cap_r   <= cap_nxt;
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else if (cmd.clear) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (cmd.wr_byte) begin
        wp_r <= advance(wp_r, cap_r);
      end
      if (cmd.commit_wr) begin
        count_r <= count_r + len_ext;
      end
      if (cmd.commit_rd && rem_r) begin
        rp_r    <= walk_r;
        count_r <= count_r - len_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      mem[wp_r] <= wdata_r[{idx_r[2:0], 3'b000} +: 8];
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[walk_r];
    end
  end

  assign out_transferred = moved_r;
  assign out_read_bytes  = rdata_r;
  assign out_occupancy   = count_r[brf_pkg::CFG_W-1:0];
  assign out_full_res    = (count_r == cap_r);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("stored count above capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (AW'(wp_r) < AW'(cap_r)) && (AW'(rp_r) < AW'(cap_r)))
    else $error("pointer outside capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_byte || cmd.rd_issue) |-> (idx_r < len_r))
    else $error("byte index past item length");
`endif

endmodule

`default_nettype wire

### src/byte_ring_fifo.sv
`default_nettype none

// Byte ring buffer with all-or-nothing transfers of up to eight bytes. Raise
// start while busy is low to hand in one command; busy stays high until its
// result has been shown. The result appears for exactly one cycle with
// out_valid high and cannot be held off, so capture it then. All bytes pass
// through a single-port byte memory: a write stores its bytes one at a time,
// and a read issues the address and then takes the registered data for each
// byte. Clear, refusals and the unused command pass straight to the result.
// The capacity register is written only while idle with start low; a write
// also empties the buffer.
module byte_ring_fifo #(
  parameter int DEPTH     = brf_pkg::DEPTH_DEF,
  parameter int MAX_BYTES = brf_pkg::MAX_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [brf_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [brf_pkg::LEN_W-1:0]  in_length,
  input  wire logic                       in_remove_after_read,
  input  wire logic [brf_pkg::DATA_W-1:0] in_write_bytes,
  output logic                            out_valid,
  output logic [brf_pkg::LEN_W-1:0]       out_transferred,
  output logic [brf_pkg::DATA_W-1:0]      out_read_bytes,
  output logic [brf_pkg::CFG_W-1:0]       out_occupancy,
  output logic                            out_full_res,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [brf_pkg::CFG_W-1:0]  cfg_data
);

  brf_pkg::ctrl_cmd_t  cmd;
  brf_pkg::dp_status_t status;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .cfg_ready (cfg_ready)
  );

  brf_datapath #(
    .DEPTH     (DEPTH),
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_cmd               (in_cmd),
    .in_length            (in_length),
    .in_remove_after_read (in_remove_after_read),
    .in_write_bytes       (in_write_bytes),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_data             (cfg_data),
    .out_transferred      (out_transferred),
    .out_read_bytes       (out_read_bytes),
    .out_occupancy        (out_occupancy),
    .out_full_res         (out_full_res)
  );

endmodule

`default_nettype wire

### verif/byte_ring_fifo_tb.sv
`timescale 1ns / 100ps

module byte_ring_fifo_tb;

  localparam logic [brf_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [brf_pkg::LEN_W-1:0]  transferred;
    logic [brf_pkg::DATA_W-1:0] read_bytes;
    logic [brf_pkg::CFG_W-1:0]  occupancy;
    logic                       full;
  } ring_reply_t;

  class ring_shadow;
    logic [7:0] shadow_mem [brf_pkg::DEPTH_DEF];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    int unsigned fill;
    logic [brf_pkg::CFG_W-1:0] cap_reg;
    ring_reply_t owed_replies[$];
    int mismatches;

    function new();
      cap_reg = brf_pkg::CFG_W'(brf_pkg::DEPTH_DEF);
      wr_ptr = 0;
      rd_ptr = 0;
      fill = 0;
      mismatches = 0;
    endfunction

    function int unsigned live_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > brf_pkg::DEPTH_DEF) return brf_pkg::DEPTH_DEF;
      return 32'(cap_reg);
    endfunction

    function int unsigned step_ptr(int unsigned p);
      return (p + 1 >= live_cap()) ? 0 : p + 1;
    endfunction

    function int owed();
      return owed_replies.size();
    endfunction

    function void note_capacity(logic [brf_pkg::CFG_W-1:0] v);
      cap_reg = v;
      wr_ptr = 0;
      rd_ptr = 0;
      fill = 0;
    endfunction

    function void note_item(logic [brf_pkg::CMD_W-1:0] cmd, logic [brf_pkg::LEN_W-1:0] len,
                            logic rm, logic [brf_pkg::DATA_W-1:0] data);
      ring_reply_t r;
      int unsigned p;
      int unsigned room;
      r = '0;
      case (cmd)
        brf_pkg::CMD_WRITE: begin
          room = (fill >= live_cap()) ? 0 : live_cap() - fill;
          if (len <= brf_pkg::MAX_BYTES_DEF && len <= room) begin
            for (int i = 0; i < len; i++) begin
              shadow_mem[wr_ptr] = data[8*i +: 8];
              wr_ptr = step_ptr(wr_ptr);
            end
            fill += 32'(len);
            r.transferred = len;
          end
        end
        brf_pkg::CMD_READ: begin
          if (len <= brf_pkg::MAX_BYTES_DEF && len <= fill) begin
            p = rd_ptr;
            for (int i = 0; i < len; i++) begin
              r.read_bytes[8*i +: 8] = shadow_mem[p];
              p = step_ptr(p);
            end
            if (rm) begin
              rd_ptr = p;
              fill -= 32'(len);
            end
            r.transferred = len;
          end
        end
        brf_pkg::CMD_CLEAR: begin
          wr_ptr = 0;
          rd_ptr = 0;
          fill = 0;
        end
        default: ;
      endcase
      r.occupancy = brf_pkg::CFG_W'(fill);
      r.full = (fill == live_cap());
      owed_replies.push_back(r);
    endfunction

    task flag(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
    endtask

    task check_reply(ring_reply_t got);
      ring_reply_t want;
      if (owed_replies.size() == 0) begin
        flag("result beat with no command outstanding");
        return;
      end
      want = owed_replies.pop_front();
      if (got.transferred !== want.transferred)
        flag($sformatf("transferred %0d, want %0d", got.transferred, want.transferred));
      if (got.read_bytes !== want.read_bytes)
        flag($sformatf("read_bytes %h, want %h", got.read_bytes, want.read_bytes));
      if (got.occupancy !== want.occupancy)
        flag($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      if (got.full !== want.full)
        flag($sformatf("full_res %b, want %b", got.full, want.full));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [brf_pkg::CMD_W-1:0] in_cmd = '0;
  logic [brf_pkg::LEN_W-1:0] in_length = '0;
  logic in_remove_after_read = 1'b0;
  logic [brf_pkg::DATA_W-1:0] in_write_bytes = '0;
  logic out_valid;
  logic [brf_pkg::LEN_W-1:0] out_transferred;
  logic [brf_pkg::DATA_W-1:0] out_read_bytes;
  logic [brf_pkg::CFG_W-1:0] out_occupancy;
  logic out_full_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brf_pkg::CFG_W-1:0] cfg_data = '0;

  ring_shadow sb;
  int quiet_cycles = 0;

  byte_ring_fifo DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_length            (in_length),
    .in_remove_after_read (in_remove_after_read),
    .in_write_bytes       (in_write_bytes),
    .out_valid            (out_valid),
    .out_transferred      (out_transferred),
    .out_read_bytes       (out_read_bytes),
    .out_occupancy        (out_occupancy),
    .out_full_res         (out_full_res),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_reply('{out_transferred, out_read_bytes, out_occupancy, out_full_res});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [brf_pkg::DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [brf_pkg::LEN_W-1:0] rand_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return brf_pkg::LEN_W'($urandom_range(9, 15));
    if (roll < 35) return brf_pkg::LEN_W'(brf_pkg::MAX_BYTES_DEF);
    return brf_pkg::LEN_W'($urandom_range(0, brf_pkg::MAX_BYTES_DEF));
  endfunction

  function automatic int next_gap(bit gappy);
    int roll;
    if (!gappy) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input logic [brf_pkg::CMD_W-1:0] cmd,
                       input logic [brf_pkg::LEN_W-1:0] len,
                       input logic rm, input logic [brf_pkg::DATA_W-1:0] data, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_length <= len;
    in_remove_after_read <= rm;
    in_write_bytes <= data;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(cmd, len, rm, data);
  endtask

  task automatic write_capacity(input logic [brf_pkg::CFG_W-1:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.note_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [brf_pkg::CFG_W-1:0] cap, input int items,
                              input int wr_pct);
    bit gappy;
    int roll;
    int n;
    write_capacity(cap);
    gappy = ($urandom_range(0, 3) != 0);
    for (n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < wr_pct)
        issue(brf_pkg::CMD_WRITE, rand_len(), 1'($urandom_range(0, 1)), rand_data(),
              next_gap(gappy));
      else if (roll < 94)
        issue(brf_pkg::CMD_READ, rand_len(), $urandom_range(0, 3) != 0, rand_data(),
              next_gap(gappy));
      else if (roll < 97)
        issue(brf_pkg::CMD_CLEAR, brf_pkg::LEN_W'($urandom), 1'($urandom), rand_data(),
              next_gap(gappy));
      else
        issue(CMD_NONE, brf_pkg::LEN_W'($urandom), 1'($urandom), rand_data(),
              next_gap(gappy));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(brf_pkg::CMD_READ, 4'd1, 1'b1, rand_data(), 0);
    issue(brf_pkg::CMD_WRITE, 4'd0, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_WRITE, 4'd8, 1'b0, '1, 0);
    issue(brf_pkg::CMD_WRITE, 4'd15, 1'b1, rand_data(), 1);
    issue(brf_pkg::CMD_READ, 4'd8, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd9, 1'b1, rand_data(), 2);
    issue(CMD_NONE, 4'd8, 1'b1, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd8, 1'b1, rand_data(), 0);
    issue(brf_pkg::CMD_WRITE, 4'd8, 1'b1, '0, 0);
    issue(brf_pkg::CMD_CLEAR, 4'd8, 1'b1, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd0, 1'b1, rand_data(), 0);

    write_capacity('0);
    issue(brf_pkg::CMD_WRITE, 4'd1, 1'b0, 64'hA5, 0);
    issue(brf_pkg::CMD_WRITE, 4'd1, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd1, 1'b1, rand_data(), 0);
    issue(brf_pkg::CMD_WRITE, 4'd2, 1'b0, rand_data(), 0);

    write_capacity(11'd5);
    issue(brf_pkg::CMD_WRITE, 4'd4, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_WRITE, 4'd1, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd3, 1'b1, rand_data(), 0);
    issue(brf_pkg::CMD_WRITE, 4'd3, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd5, 1'b0, rand_data(), 0);
    issue(brf_pkg::CMD_READ, 4'd5, 1'b1, rand_data(), 0);

    random_phase('1, 170, 85);
    random_phase(11'd1, 60, 50);
    random_phase(11'd2, 60, 50);
    random_phase(brf_pkg::CFG_W'($urandom_range(3, 16)), 100, 55);
    random_phase(brf_pkg::CFG_W'($urandom_range(17, 64)), 100, 60);
    random_phase(brf_pkg::CFG_W'($urandom_range(65, brf_pkg::DEPTH_DEF)), 80, 60);
    random_phase(brf_pkg::CFG_W'($urandom_range(brf_pkg::DEPTH_DEF + 1, 2046)), 60, 45);
    random_phase(brf_pkg::CFG_W'(brf_pkg::DEPTH_DEF), 60, 50);
    random_phase(brf_pkg::CFG_W'($urandom), 60, 55);

    @(negedge clk);
    start <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
src/brf_pkg.sv
src/brf_ctrl.sv
src/brf_datapath.sv
src/byte_ring_fifo.sv
verif/byte_ring_fifo_tb.sv
